// ----- rtl/core/uvsm_pkg.sv -----
// Shared types, constants and elaboration-time helpers for the UV sphere mesh generator.
// Holds the quarter-wave sine table, the job record passed from front to back, and the
// result record. Depends on nothing.
package uvsm_pkg;

  // Request kinds carried on the input tuser bit.
  localparam logic REQ_VERTEX   = 1'b0;
  localparam logic REQ_TRIANGLE = 1'b1;

  // Field widths fixed by the interface.
  localparam int NUM_W    = 10;
  localparam int RAD_W    = 16;
  localparam int POS_W    = 17;
  localparam int NORM_W   = 16;
  localparam int TEX_W    = 17;
  localparam int CORNER_W = 9;

  // Ring and column indices cover the largest supported sphere (64 stacks, 64 slices).
  localparam int RING_W = 6;
  localparam int RING_N = 64;
  localparam int COL_W  = 7;
  localparam int COL_N  = 65;

  // Front-to-back queue.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // Quarter-wave sine, Q1.14, steps of pi/64.
  localparam int QSIN [0:32] = '{
    0, 804, 1606, 2404, 3196, 3981, 4756, 5520,
    6270, 7005, 7723, 8423, 9102, 9760, 10394, 11003,
    11585, 12140, 12665, 13160, 13623, 14053, 14449, 14811,
    15137, 15426, 15679, 15893, 16069, 16207, 16305, 16364,
    16384
  };

  // Classified request as it leaves the front end.
  typedef struct packed {
    logic                is_vert;
    logic                ok;
    logic                pole_n;
    logic                pole_s;
    logic [RING_W-1:0]   ring;
    logic [COL_W-1:0]    col;
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [CORNER_W-1:0] corner_c;
  } uvsm_job_t;

  // One row of the per-ring angle table.
  typedef struct packed {
    logic signed [NORM_W-1:0] sin_p;
    logic signed [NORM_W-1:0] cos_p;
    logic [TEX_W-1:0]         tex_v;
  } uvsm_ring_t;

  // One row of the per-column angle table.
  typedef struct packed {
    logic signed [NORM_W-1:0] sin_a;
    logic signed [NORM_W-1:0] cos_a;
    logic [TEX_W-1:0]         tex_u;
  } uvsm_col_t;

  typedef uvsm_ring_t [RING_N-1:0] uvsm_ring_tab_t;
  typedef uvsm_col_t  [COL_N-1:0]  uvsm_col_tab_t;

  // Finished result item.
  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [TEX_W-1:0]         tex_u;
    logic [TEX_W-1:0]         tex_v;
    logic [CORNER_W-1:0]      corner_a;
    logic [CORNER_W-1:0]      corner_b;
    logic [CORNER_W-1:0]      corner_c;
    logic                     valid_res;
  } uvsm_res_t;

  // Sine over one quarter, argument 0..16384, interpolated with rounding.
  function automatic int quarter_sin(input int r);
    int i;
    int f;
    int d;
    if (r >= 16384) begin
      return 16384;
    end
    i = r >> 9;
    f = r & 511;
    d = QSIN[i + 1] - QSIN[i];
    return QSIN[i] + ((d * f + 256) >> 9);
  endfunction

  // Sine of a 16-bit phase, Q1.14.
  function automatic int phase_sin(input int p);
    int pm;
    int q;
    int r;
    int s;
    pm = p & 65535;
    q  = pm >> 14;
    r  = pm & 16383;
    s  = ((q & 1) != 0) ? quarter_sin(16384 - r) : quarter_sin(r);
    return ((q & 2) != 0) ? -s : s;
  endfunction

  // Rescale a Q1.14 product by 2^-14, rounding to nearest with ties away from zero.
  function automatic logic signed [POS_W-1:0] round14(input logic signed [31:0] p);
    logic signed [31:0] s;
    s = (p + ((p < 0) ? 32'sd8191 : 32'sd8192)) >>> 14;
    return s[POS_W-1:0];
  endfunction

endpackage

// ----- rtl/core/uvsm_front.sv -----
// Front end of the UV sphere mesh generator: takes requests, checks their range and
// splits the item number into ring and column, or into triangle corners.
// Depends on uvsm_pkg.
module uvsm_front #(
  parameter int STACKS = 20,
  parameter int SLICES = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [uvsm_pkg::NUM_W-1:0]   in_num,
  input  logic                         q_full,
  output logic                         q_push,
  output uvsm_pkg::uvsm_job_t          q_job
);
  import uvsm_pkg::*;

  localparam int NRING = SLICES + 1;
  localparam int NVERT = 2 + (STACKS - 1) * NRING;
  localparam int NTRI  = 2 * SLICES * (STACKS - 1);
  localparam int NMID  = 2 * SLICES * (STACKS - 2);
  localparam int SH    = 20;

  // Ceiling reciprocals: exact quotients for any dividend below 1024 and divisor up to 65.
  localparam logic [19:0] RCP_V = 20'((1 << SH) / NRING + 1);
  localparam logic [19:0] RCP_T = 20'((1 << SH) / SLICES + 1);
  localparam logic [6:0]  DIV_V = 7'(NRING);
  localparam logic [6:0]  DIV_T = 7'(SLICES);

  localparam logic [15:0] NVERT_W   = 16'(NVERT);
  localparam logic [15:0] NTRI_W    = 16'(NTRI);
  localparam logic [15:0] NMID_W    = 16'(NMID);
  localparam logic [15:0] SLICES_W  = 16'(SLICES);
  localparam logic [15:0] NRING_W   = 16'(NRING);
  localparam logic [15:0] BOTTOM_W  = 16'(NVERT - 1);
  localparam logic [15:0] LAST_W    = 16'(NVERT - 1 - NRING);
  localparam logic [15:0] BOT_OFF_W = 16'(SLICES + NMID);

  // Stage one registers.
  logic               f1_v_r, f1_v_nxt;
  logic               f1_kind_r;
  logic [NUM_W-1:0]   f1_num_r;
  logic               f1_ok_r;
  logic [NUM_W-1:0]   f1_dvd_r;
  logic [29:0]        f1_prod_r;

  logic               in_fire;
  logic [15:0]        num16;
  logic [15:0]        tri_off;
  logic [NUM_W-1:0]   dvd;
  logic               ok;

  assign in_ready = !f1_v_r || !q_full;
  assign in_fire  = in_valid && in_ready;
  assign num16    = {6'd0, in_num};
  assign tri_off  = num16 - SLICES_W;

  always_comb begin
    if (in_kind == REQ_TRIANGLE) begin
      ok  = num16 < NTRI_W;
      dvd = tri_off[NUM_W:1];
    end else begin
      ok  = num16 < NVERT_W;
      dvd = in_num - 10'd1;
    end
  end

  assign f1_v_nxt = in_fire ? 1'b1 : (f1_v_r && !q_push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= f1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      f1_kind_r <= in_kind;
      f1_num_r  <= in_num;
      f1_ok_r   <= ok;
      f1_dvd_r  <= dvd;
      f1_prod_r <= 30'(dvd) * 30'((in_kind == REQ_TRIANGLE) ? RCP_T : RCP_V);
    end
  end

  // Stage two: remainder and corner arithmetic, written straight into the queue.
  logic [NUM_W-1:0] quo;
  logic [6:0]       dvs;
  logic [16:0]      qd;
  logic [6:0]       rem;
  logic [15:0]      n16;
  logic [15:0]      t16;
  logic [15:0]      t2;
  logic [15:0]      base;
  logic [15:0]      ca, cb, cc;

  assign quo  = f1_prod_r[29:20];
  assign dvs  = (f1_kind_r == REQ_TRIANGLE) ? DIV_T : DIV_V;
  assign qd   = 17'(quo) * 17'(dvs);
  assign rem  = 7'(f1_dvd_r - qd[NUM_W-1:0]);
  assign n16  = {6'd0, f1_num_r};
  assign t16  = n16 - SLICES_W;
  assign t2   = n16 - BOT_OFF_W;
  assign base = 16'd1 + {6'd0, f1_dvd_r} + {6'd0, quo};

  always_comb begin
    ca = '0;
    cb = '0;
    cc = '0;
    if (n16 < SLICES_W) begin
      // Top cap fan around the north pole.
      cb = n16 + 16'd2;
      cc = n16 + 16'd1;
    end else if (t16 < NMID_W) begin
      if (!t16[0]) begin
        ca = base;
        cb = base + 16'd1;
        cc = base + NRING_W;
      end else begin
        ca = base + NRING_W;
        cb = base + 16'd1;
        cc = base + NRING_W + 16'd1;
      end
    end else begin
      // Bottom cap fan around the south pole.
      ca = BOTTOM_W;
      cb = LAST_W + t2;
      cc = LAST_W + t2 + 16'd1;
    end
  end

  always_comb begin
    q_job.is_vert  = (f1_kind_r == REQ_VERTEX);
    q_job.ok       = f1_ok_r;
    q_job.pole_n   = (n16 == 16'd0);
    q_job.pole_s   = (n16 == BOTTOM_W);
    q_job.ring     = quo[RING_W-1:0] + 6'd1;
    q_job.col      = rem;
    q_job.corner_a = '0;
    q_job.corner_b = '0;
    q_job.corner_c = '0;
    if (f1_ok_r && f1_kind_r == REQ_TRIANGLE) begin
      q_job.corner_a = ca[CORNER_W-1:0];
      q_job.corner_b = cb[CORNER_W-1:0];
      q_job.corner_c = cc[CORNER_W-1:0];
    end
  end

  assign q_push = f1_v_r && !q_full;

endmodule

// ----- rtl/core/uvsm_queue.sv -----
// Short job queue between the front and back ends of the UV sphere mesh generator.
// Depends on uvsm_pkg for the job record and depth.
module uvsm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  uvsm_pkg::uvsm_job_t  push_job,
  output logic                 full,
  input  logic                 pop,
  output uvsm_pkg::uvsm_job_t  pop_job,
  output logic                 empty
);
  import uvsm_pkg::*;

  uvsm_job_t          slots_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/core/uvsm_back.sv -----
// Back end of the UV sphere mesh generator: angle lookup, normal products and radius
// scaling in three stalling stages, the last of which is the output register.
// Depends on uvsm_pkg.
module uvsm_back #(
  parameter int STACKS = 20,
  parameter int SLICES = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  uvsm_pkg::uvsm_job_t         q_job,
  output logic                        q_pop,
  input  logic [uvsm_pkg::RAD_W-1:0]  radius,
  output logic                        out_valid,
  input  logic                        out_ready,
  output uvsm_pkg::uvsm_res_t         out_res
);
  import uvsm_pkg::*;

  function automatic uvsm_ring_tab_t gen_ring();
    uvsm_ring_tab_t t;
    int pp;
    for (int y = 0; y < RING_N; y++) begin
      pp = (y * 32768 + STACKS / 2) / STACKS;
      t[y].sin_p = 16'(phase_sin(pp));
      t[y].cos_p = 16'(phase_sin(pp + 16384));
      t[y].tex_v = 17'((y * 65536 + STACKS / 2) / STACKS);
    end
    return t;
  endfunction

  function automatic uvsm_col_tab_t gen_col();
    uvsm_col_tab_t t;
    int pa;
    for (int x = 0; x < COL_N; x++) begin
      pa = (x * 65536 + SLICES / 2) / SLICES;
      t[x].sin_a = 16'(phase_sin(pa));
      t[x].cos_a = 16'(phase_sin(pa + 16384));
      t[x].tex_u = 17'(pa);
    end
    return t;
  endfunction

  localparam uvsm_ring_tab_t RING_TAB = gen_ring();
  localparam uvsm_col_tab_t  COL_TAB  = gen_col();

  logic rdy1, rdy2, rdy3;

  // Stage one: table lookup and pole handling.
  logic                     b1_v_r;
  logic signed [NORM_W-1:0] b1_sp_r, b1_ca_r, b1_sa_r, b1_ny_r;
  logic [TEX_W-1:0]         b1_u_r, b1_v_tex_r;
  logic [CORNER_W-1:0]      b1_a_r, b1_b_r, b1_c_r;
  logic                     b1_ok_r;

  logic signed [NORM_W-1:0] sp_nxt, ca_nxt, sa_nxt, ny_nxt;
  logic [TEX_W-1:0]         u_nxt, v_nxt;
  uvsm_ring_t               ring_e;
  uvsm_col_t                col_e;

  // Stage two: normals.
  logic                     b2_v_r;
  logic signed [NORM_W-1:0] b2_nx_r, b2_ny_r, b2_nz_r;
  logic [TEX_W-1:0]         b2_u_r, b2_v_tex_r;
  logic [CORNER_W-1:0]      b2_a_r, b2_b_r, b2_c_r;
  logic                     b2_ok_r;

  logic signed [31:0]       px_prod, pz_prod;
  logic signed [POS_W-1:0]  nx_full, nz_full;

  // Stage three: positions, held as the output register.
  logic                     o_v_r;
  uvsm_res_t                o_res_r;
  logic signed [31:0]       rx_prod, ry_prod, rz_prod;
  logic signed [POS_W-1:0]  rad_s;

  assign rdy3  = !o_v_r || out_ready;
  assign rdy2  = !b2_v_r || rdy3;
  assign rdy1  = !b1_v_r || rdy2;
  assign q_pop = !q_empty && rdy1;

  assign ring_e = RING_TAB[q_job.ring];
  assign col_e  = COL_TAB[q_job.col];

  always_comb begin
    sp_nxt = '0;
    ca_nxt = '0;
    sa_nxt = '0;
    ny_nxt = '0;
    u_nxt  = '0;
    v_nxt  = '0;
    if (q_job.ok && q_job.is_vert) begin
      if (q_job.pole_n) begin
        ny_nxt = 16'sd16384;
        u_nxt  = 17'd32768;
      end else if (q_job.pole_s) begin
        ny_nxt = -16'sd16384;
        u_nxt  = 17'd32768;
        v_nxt  = 17'd65536;
      end else begin
        sp_nxt = ring_e.sin_p;
        ca_nxt = col_e.cos_a;
        sa_nxt = col_e.sin_a;
        ny_nxt = ring_e.cos_p;
        u_nxt  = col_e.tex_u;
        v_nxt  = ring_e.tex_v;
      end
    end
  end

  assign px_prod = 32'(b1_sp_r) * 32'(b1_ca_r);
  assign pz_prod = 32'(b1_sp_r) * 32'(b1_sa_r);
  assign nx_full = round14(px_prod);
  assign nz_full = round14(pz_prod);

  assign rad_s   = $signed({1'b0, radius});
  assign rx_prod = 32'(rad_s) * 32'(b2_nx_r);
  assign ry_prod = 32'(rad_s) * 32'(b2_ny_r);
  assign rz_prod = 32'(rad_s) * 32'(b2_nz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (rdy1) begin
        b1_v_r <= !q_empty;
      end
      if (rdy2) begin
        b2_v_r <= b1_v_r;
      end
      if (rdy3) begin
        o_v_r <= b2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_sp_r    <= sp_nxt;
      b1_ca_r    <= ca_nxt;
      b1_sa_r    <= sa_nxt;
      b1_ny_r    <= ny_nxt;
      b1_u_r     <= u_nxt;
      b1_v_tex_r <= v_nxt;
      b1_a_r     <= q_job.corner_a;
      b1_b_r     <= q_job.corner_b;
      b1_c_r     <= q_job.corner_c;
      b1_ok_r    <= q_job.ok;
    end
    if (rdy2 && b1_v_r) begin
      b2_nx_r    <= nx_full[NORM_W-1:0];
      b2_nz_r    <= nz_full[NORM_W-1:0];
      b2_ny_r    <= b1_ny_r;
      b2_u_r     <= b1_u_r;
      b2_v_tex_r <= b1_v_tex_r;
      b2_a_r     <= b1_a_r;
      b2_b_r     <= b1_b_r;
      b2_c_r     <= b1_c_r;
      b2_ok_r    <= b1_ok_r;
    end
    if (rdy3 && b2_v_r) begin
      o_res_r.pos_x     <= round14(rx_prod);
      o_res_r.pos_y     <= round14(ry_prod);
      o_res_r.pos_z     <= round14(rz_prod);
      o_res_r.norm_x    <= b2_nx_r;
      o_res_r.norm_y    <= b2_ny_r;
      o_res_r.norm_z    <= b2_nz_r;
      o_res_r.tex_u     <= b2_u_r;
      o_res_r.tex_v     <= b2_v_tex_r;
      o_res_r.corner_a  <= b2_a_r;
      o_res_r.corner_b  <= b2_b_r;
      o_res_r.corner_c  <= b2_c_r;
      o_res_r.valid_res <= b2_ok_r;
    end
  end

  assign out_valid = o_v_r;
  assign out_res   = o_res_r;

endmodule

// ----- rtl/core/uv_sphere_mesh_generator.sv -----
// Top level of the UV sphere mesh generator: stream ports, radius register and the
// front end, job queue and back end. Depends on uvsm_pkg, uvsm_front, uvsm_queue, uvsm_back.
//
//  Channel  Dir  Handshake                Payload
//  in       in   in_tvalid / in_tready    in_tdata (item number), in_tuser (request kind)
//  out      out  out_tvalid / out_tready  out_tdata (result fields), out_tuser (valid flag)
//  cfg      in   cfg_valid / cfg_ready    cfg_data (sphere radius, Q8.8)
//
// One item is taken every cycle while the queue has room; the two rounds of 16 by 16
// multiplication in the back end are pipelined, so they set no limit on the rate.
// A result is offered once its item has passed the front-end register, the job queue and
// the back-end stages, later if it waits in the queue behind a stalled output.
// Reset is synchronous and active low; it empties the pipeline and sets the radius to 1.0.
// A stalled output holds the back end while the front end keeps filling the four-entry queue.
// The radius may be written only while no item is in flight.
module uv_sphere_mesh_generator #(
  parameter int STACKS = 20,
  parameter int SLICES = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  // Requests.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // [9:0] item_number, [15:10] zero
  input  logic         in_tuser,   // [0] req_type
  // Radius writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  // Results.
  output logic         out_tvalid,
  input  logic         out_tready,
  // [16:0] pos_x, [33:17] pos_y, [50:34] pos_z, [66:51] norm_x, [82:67] norm_y,
  // [98:83] norm_z, [115:99] tex_u, [132:116] tex_v, [141:133] corner_a,
  // [150:142] corner_b, [159:151] corner_c
  output logic [159:0] out_tdata,
  output logic         out_tuser   // [0] valid_res
);
  import uvsm_pkg::*;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd256;

  logic [RAD_W-1:0] radius_r;
  logic             q_push, q_full, q_pop, q_empty;
  uvsm_job_t        push_job, pop_job;
  uvsm_res_t        res;

  // The radius register takes a write in every cycle it is offered one.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius_r <= cfg_data;
    end
  end

  // The front end classifies each request and resolves ring, column or corners.
  uvsm_front #(
    .STACKS (STACKS),
    .SLICES (SLICES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_tuser),
    .in_num   (in_tdata[NUM_W-1:0]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // The queue lets the front end keep taking items while the output is stalled.
  uvsm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // The back end looks up angles and forms normals, then positions.
  uvsm_back #(
    .STACKS (STACKS),
    .SLICES (SLICES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .radius    (radius_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {res.corner_c, res.corner_b, res.corner_a, res.tex_v, res.tex_u,
                      res.norm_z, res.norm_y, res.norm_x, res.pos_z, res.pos_y, res.pos_x};
  assign out_tuser = res.valid_res;

`ifndef NO_ASSERTIONS
  // A request out of range must come out with every field cleared.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("out-of-range result carries non-zero fields");

  // The normal's y part never leaves the unit range.
  a_norm_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(res.norm_y) <= 16'sd16384 && $signed(res.norm_y) >= -16'sd16384))
    else $error("normal y outside unit range");

  // The back end never takes a job from an empty queue, nor the front end push into a full one.
  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty) && !(q_push && q_full))
    else $error("job queue underflow or overflow");
`endif

endmodule

// ----- dv/uv_sphere_mesh_checker.sv -----
// Result checker for the UV sphere mesh generator: watches the request, radius and result
// channels, predicts every result and compares it field by field. Depends on uvsm_pkg.
`timescale 1ns / 1ps

module uv_sphere_mesh_checker #(
  parameter int STACKS = 20,
  parameter int SLICES = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [15:0]  in_tdata,   // [9:0] item_number, [15:10] zero
  input  logic         in_tuser,   // [0] req_type
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  input  logic         out_tvalid,
  input  logic         out_tready,
  // [16:0] pos_x, [33:17] pos_y, [50:34] pos_z, [66:51] norm_x, [82:67] norm_y,
  // [98:83] norm_z, [115:99] tex_u, [132:116] tex_v, [141:133] corner_a,
  // [150:142] corner_b, [159:151] corner_c
  input  logic [159:0] out_tdata,
  input  logic         out_tuser,  // [0] valid_res
  output int unsigned  mismatch_count,
  output int unsigned  results_checked,
  output int unsigned  outstanding
);
  import uvsm_pkg::*;

  localparam int RING_LEN   = SLICES + 1;
  localparam int VERT_COUNT = 2 + (STACKS - 1) * RING_LEN;
  localparam int MID_COUNT  = 2 * SLICES * (STACKS - 2);
  localparam int TRI_COUNT  = 2 * SLICES * (STACKS - 1);
  localparam int REPORT_LIMIT = 10;

  // Quarter wave of the sine in Q1.14, one node every pi/64.
  localparam int QUARTER_WAVE [0:32] = '{
    0, 804, 1606, 2404, 3196, 3981, 4756, 5520,
    6270, 7005, 7723, 8423, 9102, 9760, 10394, 11003,
    11585, 12140, 12665, 13160, 13623, 14053, 14449, 14811,
    15137, 15426, 15679, 15893, 16069, 16207, 16305, 16364,
    16384
  };

  typedef struct packed {
    logic                kind;
    logic [NUM_W-1:0]    num;
    uvsm_res_t           res;
  } mesh_expect_t;

  mesh_expect_t      expected_items [$];
  logic [RAD_W-1:0]  radius_copy;
  int unsigned       mismatches = 0;
  int unsigned       checked = 0;

  assign mismatch_count  = mismatches;
  assign results_checked = checked;

  // Sine of a 16-bit turn phase, Q1.14, folded onto the quarter wave and interpolated.
  function automatic int wave_sine(input int phase);
    int turn;
    int offs;
    int node;
    int frac;
    int mag;
    turn = phase & 16'hFFFF;
    offs = turn & 16'h3FFF;
    if (turn[14]) begin
      offs = 16384 - offs;
    end
    if (offs >= 16384) begin
      mag = 16384;
    end else begin
      node = offs >> 9;
      frac = offs & 511;
      mag  = QUARTER_WAVE[node]
           + (((QUARTER_WAVE[node + 1] - QUARTER_WAVE[node]) * frac + 256) >> 9);
    end
    return turn[15] ? -mag : mag;
  endfunction

  // Product rescaled by 2^-14, rounded to nearest with ties away from zero.
  function automatic int q14_product(input int a, input int b);
    longint prod;
    longint mag;
    prod = longint'(a) * longint'(b);
    mag  = (prod < 0) ? -prod : prod;
    mag  = (mag + 8192) >>> 14;
    return (prod < 0) ? -int'(mag) : int'(mag);
  endfunction

  function automatic uvsm_res_t predict_mesh_item(input logic kind, input int num,
                                                  input int rad);
    uvsm_res_t res;
    int nx, ny, nz, u, v;
    int ring, col, polar, azim, sp;
    int t, pair, row, base;
    res = '0;
    if (kind == REQ_VERTEX) begin
      if (num >= VERT_COUNT) begin
        return res;
      end
      if (num == 0 || num == VERT_COUNT - 1) begin
        // The poles have a fixed normal whatever the radius.
        nx = 0;
        nz = 0;
        ny = (num == 0) ? 16384 : -16384;
        u  = 32768;
        v  = (num == 0) ? 0 : 65536;
      end else begin
        ring  = (num - 1) / RING_LEN + 1;
        col   = (num - 1) % RING_LEN;
        polar = (ring * 32768 + STACKS / 2) / STACKS;
        azim  = (col * 65536 + SLICES / 2) / SLICES;
        sp    = wave_sine(polar);
        nx    = q14_product(sp, wave_sine(azim + 16384));
        ny    = wave_sine(polar + 16384);
        nz    = q14_product(sp, wave_sine(azim));
        u     = azim;
        v     = (ring * 65536 + STACKS / 2) / STACKS;
      end
      res.pos_x  = 17'(q14_product(rad, nx));
      res.pos_y  = 17'(q14_product(rad, ny));
      res.pos_z  = 17'(q14_product(rad, nz));
      res.norm_x = 16'(nx);
      res.norm_y = 16'(ny);
      res.norm_z = 16'(nz);
      res.tex_u  = 17'(u);
      res.tex_v  = 17'(v);
    end else begin
      if (num >= TRI_COUNT) begin
        return res;
      end
      if (num < SLICES) begin
        res.corner_a = '0;
        res.corner_b = 9'(num + 2);
        res.corner_c = 9'(num + 1);
      end else if (num - SLICES < MID_COUNT) begin
        t    = num - SLICES;
        pair = t >> 1;
        row  = pair / SLICES;
        base = 1 + row * RING_LEN + pair % SLICES;
        if (t[0] == 1'b0) begin
          res.corner_a = 9'(base);
          res.corner_b = 9'(base + 1);
          res.corner_c = 9'(base + RING_LEN);
        end else begin
          res.corner_a = 9'(base + RING_LEN);
          res.corner_b = 9'(base + 1);
          res.corner_c = 9'(base + RING_LEN + 1);
        end
      end else begin
        t    = num - SLICES - MID_COUNT;
        base = VERT_COUNT - 1 - RING_LEN;
        res.corner_a = 9'(VERT_COUNT - 1);
        res.corner_b = 9'(base + t);
        res.corner_c = 9'(base + t + 1);
      end
    end
    res.valid_res = 1'b1;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [16:0] want,
                             input logic [16:0] got, input mesh_expect_t req);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t ns: %s %0d, %s: expected 0x%0h, got 0x%0h", $time,
                 (req.kind == REQ_VERTEX) ? "vertex" : "triangle", req.num, field,
                 want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    mesh_expect_t head;
    uvsm_res_t    got;
    if (!rst_n) begin
      radius_copy = 16'd256;
      expected_items.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radius_copy = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        if (expected_items.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t ns: result arrived with none outstanding", $time);
          end
        end else begin
          head = expected_items.pop_front();
          got.pos_x     = out_tdata[16:0];
          got.pos_y     = out_tdata[33:17];
          got.pos_z     = out_tdata[50:34];
          got.norm_x    = out_tdata[66:51];
          got.norm_y    = out_tdata[82:67];
          got.norm_z    = out_tdata[98:83];
          got.tex_u     = out_tdata[115:99];
          got.tex_v     = out_tdata[132:116];
          got.corner_a  = out_tdata[141:133];
          got.corner_b  = out_tdata[150:142];
          got.corner_c  = out_tdata[159:151];
          got.valid_res = out_tuser;
          check_field("pos_x", head.res.pos_x, got.pos_x, head);
          check_field("pos_y", head.res.pos_y, got.pos_y, head);
          check_field("pos_z", head.res.pos_z, got.pos_z, head);
          check_field("norm_x", 17'(head.res.norm_x), 17'(got.norm_x), head);
          check_field("norm_y", 17'(head.res.norm_y), 17'(got.norm_y), head);
          check_field("norm_z", 17'(head.res.norm_z), 17'(got.norm_z), head);
          check_field("tex_u", head.res.tex_u, got.tex_u, head);
          check_field("tex_v", head.res.tex_v, got.tex_v, head);
          check_field("corner_a", 17'(head.res.corner_a), 17'(got.corner_a), head);
          check_field("corner_b", 17'(head.res.corner_b), 17'(got.corner_b), head);
          check_field("corner_c", 17'(head.res.corner_c), 17'(got.corner_c), head);
          check_field("valid_res", 17'(head.res.valid_res), 17'(got.valid_res), head);
          checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        head.kind = in_tuser;
        head.num  = in_tdata[NUM_W-1:0];
        head.res  = predict_mesh_item(in_tuser, int'(in_tdata[NUM_W-1:0]),
                                      int'(radius_copy));
        expected_items = {expected_items, head};
      end
      outstanding <= expected_items.size();
    end
  end

endmodule

// ----- dv/uv_sphere_mesh_generator_test.sv -----
// Top of the UV sphere mesh generator testbench: clock, reset, requests, radius writes,
// output back-pressure and the verdict. Depends on uvsm_pkg and uv_sphere_mesh_checker.
`timescale 1ns / 1ps

module uv_sphere_mesh_generator_test;
  import uvsm_pkg::*;

  localparam int STACKS     = 20;
  localparam int SLICES     = 20;
  localparam int RING_LEN   = SLICES + 1;
  localparam int VERT_COUNT = 2 + (STACKS - 1) * RING_LEN;
  localparam int MID_COUNT  = 2 * SLICES * (STACKS - 2);
  localparam int TRI_COUNT  = 2 * SLICES * (STACKS - 1);

  localparam int CLK_PERIOD     = 20;
  localparam int PHASES         = 6;
  localparam int ITEMS_PER_PHASE = 88;
  // The margin after the final drain covers a late spurious result.
  localparam int SETTLE_CYCLES  = 16;
  // The slowest correct run is some 600 items, well within this bound.
  localparam int TIMEOUT_CYCLES = 250_000;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [15:0]  in_tdata;
  logic         in_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [15:0]  cfg_data;
  logic         out_tvalid;
  logic         out_tready;
  logic [159:0] out_tdata;
  logic         out_tuser;

  int unsigned  mismatch_count;
  int unsigned  results_checked;
  int unsigned  outstanding;

  // When set, neither side idles: the last phase of the run goes at full rate.
  bit           quiet = 1'b0;

  int unsigned  vert_sent = 0;
  int unsigned  tri_sent = 0;
  int unsigned  out_of_range_sent = 0;
  int unsigned  radius_settings = 1;

  always #(CLK_PERIOD / 2) clk = ~clk;

  uv_sphere_mesh_generator #(
    .STACKS (STACKS),
    .SLICES (SLICES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  uv_sphere_mesh_checker #(
    .STACKS (STACKS),
    .SLICES (SLICES)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .mismatch_count  (mismatch_count),
    .results_checked (results_checked),
    .outstanding     (outstanding)
  );

  // Offers one request item and returns once it has been taken. Now and then the valid
  // is dropped for a short burst first, so that gaps land on every stage of the pipeline.
  // Handshake signals are read just after the edge, before any of that edge's updates.
  task automatic send_request(input logic kind, input int num);
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= 16'(num);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == REQ_VERTEX) begin
      vert_sent++;
      if (num >= VERT_COUNT) begin
        out_of_range_sent++;
      end
    end else begin
      tri_sent++;
      if (num >= TRI_COUNT) begin
        out_of_range_sent++;
      end
    end
  endtask

  // Stops sending and waits until every outstanding result has come back. The checker
  // updates its count at the edge, so the value seen here always belongs to the last edge.
  task automatic drain_requests();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Radius writes happen only with the pipeline empty.
  task automatic write_radius(input logic [RAD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    radius_settings++;
  endtask

  // Output back-pressure: random stall bursts, none once the run goes quiet.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 99) < 20) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    int               pick;
    logic             kind;
    int               num;
    logic [RAD_W-1:0] radius_value;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_VERTEX;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at the reset radius of 1.0. Vertices first: the north pole, the
    // start of the first ring, its repeated seam vertex, the vertex after the seam, the
    // last ring vertex, the south pole, then numbers just and far beyond the last vertex.
    send_request(REQ_VERTEX, 0);
    send_request(REQ_VERTEX, 1);
    send_request(REQ_VERTEX, RING_LEN);
    send_request(REQ_VERTEX, RING_LEN + 1);
    send_request(REQ_VERTEX, VERT_COUNT - 2);
    send_request(REQ_VERTEX, VERT_COUNT - 1);
    send_request(REQ_VERTEX, VERT_COUNT);
    send_request(REQ_VERTEX, 1023);
    // Triangles: both ends of the top cap, an even and an odd triangle at the start of
    // the middle band, its last one, both ends of the bottom cap and two numbers beyond.
    send_request(REQ_TRIANGLE, 0);
    send_request(REQ_TRIANGLE, SLICES - 1);
    send_request(REQ_TRIANGLE, SLICES);
    send_request(REQ_TRIANGLE, SLICES + 1);
    send_request(REQ_TRIANGLE, SLICES + MID_COUNT - 1);
    send_request(REQ_TRIANGLE, SLICES + MID_COUNT);
    send_request(REQ_TRIANGLE, TRI_COUNT - 1);
    send_request(REQ_TRIANGLE, TRI_COUNT);
    send_request(REQ_TRIANGLE, 1023);

    // Random phases, each under its own radius: zero and full scale first, then the
    // smallest non-zero value, then random ones. The last phase runs without idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       radius_value = 16'h0000;
        1:       radius_value = 16'hFFFF;
        2:       radius_value = 16'h0001;
        default: radius_value = 16'($urandom_range(0, 16'hFFFF));
      endcase
      drain_requests();
      quiet = (phase == PHASES - 1);
      write_radius(radius_value);
      // The poles are special at every radius, zero included.
      send_request(REQ_VERTEX, 0);
      send_request(REQ_VERTEX, VERT_COUNT - 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Once in the run the sender holds off until the pipeline has emptied.
        if (phase == 1 && k == ITEMS_PER_PHASE / 2) begin
          drain_requests();
        end
        // Mostly valid vertices and triangles, with some numbers from the whole range.
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          kind = REQ_VERTEX;
          num  = $urandom_range(0, VERT_COUNT - 1);
        end else if (pick < 90) begin
          kind = REQ_TRIANGLE;
          num  = $urandom_range(0, TRI_COUNT - 1);
        end else begin
          kind = $urandom_range(0, 1) ? REQ_TRIANGLE : REQ_VERTEX;
          num  = $urandom_range(0, 1023);
        end
        send_request(kind, num);
      end
    end

    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d vertex and %0d triangle requests, %0d out of range, under %0d radii.",
             vert_sent, tri_sent, out_of_range_sent, radius_settings);
    $display("Checked %0d results field by field, %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d results outstanding.", outstanding);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
